[src/plfr_pkg.sv]
// ----------------------------------------------------------------------------
// plfr_pkg: shared types and constants of the panel frame store refresher
// Command codes, phase encoding, set-up bytes and the microcode table that
// steers the datapath of page_lcd_framebuffer_refresh.
// ----------------------------------------------------------------------------
package plfr_pkg;

  // Command codes carried on in_tuser.
  localparam logic [2:0] CMD_DRAW     = 3'd0;
  localparam logic [2:0] CMD_CLEAR    = 3'd1;
  localparam logic [2:0] CMD_FLUSH    = 3'd2;
  localparam logic [2:0] CMD_TICK     = 3'd3;
  localparam logic [2:0] CMD_INIT     = 3'd4;
  localparam logic [2:0] CMD_SHUTDOWN = 3'd5;

  // Panel command bytes.
  localparam logic [3:0] PAGE_CMD_HI  = 4'hB;
  localparam logic [7:0] COL_LO_CMD   = 8'h00;
  localparam logic [7:0] COL_HI_CMD   = 8'h10;
  localparam logic [7:0] DISP_OFF_CMD = 8'hAE;

  localparam int unsigned SETUP_LEN = 8;
  localparam logic [7:0] SETUP_BYTES [SETUP_LEN] = '{
    8'hA0, 8'hA2, 8'hC0, 8'h2F, 8'h2F, 8'h24, 8'h40, 8'hAF
  };

  // Sequence phase, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_INIT = 5'b00010,
    PH_HEAD = 5'b00100,
    PH_DATA = 5'b01000,
    PH_OFF  = 5'b10000
  } phase_t;

  // Microcode fields.
  typedef logic [3:0] upc_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_NO_BEAT,
    C_NOT_DRAW,
    C_DRAW_SKIP,
    C_NOT_TICK,
    C_IDLE_PHASE,
    C_OUT_FULL,
    C_NO_CLEAR,
    C_SWEEP_DONE
  } cond_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_DRAW_RD,
    OP_DRAW_WR,
    OP_TICK_RD,
    OP_EMIT,
    OP_CTRL,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    NX_INC,
    NX_WAIT,
    NX_SELF
  } nxt_t;

  // When cond holds the step jumps to target and its op is skipped;
  // otherwise the op runs and the step counter moves as nxt says.
  typedef struct packed {
    cond_t cond;
    upc_t  target;
    op_t   op;
    nxt_t  nxt;
  } ucw_t;

  localparam upc_t U_WAIT    = 4'd0;
  localparam upc_t U_IS_DRAW = 4'd1;
  localparam upc_t U_DRAW_RD = 4'd2;
  localparam upc_t U_DRAW_WR = 4'd3;
  localparam upc_t U_IS_TICK = 4'd4;
  localparam upc_t U_TICK_RD = 4'd5;
  localparam upc_t U_EMIT    = 4'd6;
  localparam upc_t U_CTRL    = 4'd7;
  localparam upc_t U_CLR_CHK = 4'd8;
  localparam upc_t U_SWEEP   = 4'd9;

  function automatic ucw_t ucode(input upc_t pc);
    ucw_t w;
    w = '{cond: C_NEVER, target: U_WAIT, op: OP_NONE, nxt: NX_WAIT};
    case (pc)
      U_WAIT:    w = '{cond: C_NO_BEAT,    target: U_WAIT,    op: OP_LATCH,   nxt: NX_INC};
      U_IS_DRAW: w = '{cond: C_NOT_DRAW,   target: U_IS_TICK, op: OP_NONE,    nxt: NX_INC};
      U_DRAW_RD: w = '{cond: C_DRAW_SKIP,  target: U_WAIT,    op: OP_DRAW_RD, nxt: NX_INC};
      U_DRAW_WR: w = '{cond: C_NEVER,      target: U_WAIT,    op: OP_DRAW_WR, nxt: NX_WAIT};
      U_IS_TICK: w = '{cond: C_NOT_TICK,   target: U_CTRL,    op: OP_NONE,    nxt: NX_INC};
      U_TICK_RD: w = '{cond: C_IDLE_PHASE, target: U_WAIT,    op: OP_TICK_RD, nxt: NX_INC};
      U_EMIT:    w = '{cond: C_OUT_FULL,   target: U_EMIT,    op: OP_EMIT,    nxt: NX_WAIT};
      U_CTRL:    w = '{cond: C_NEVER,      target: U_WAIT,    op: OP_CTRL,    nxt: NX_INC};
      U_CLR_CHK: w = '{cond: C_NO_CLEAR,   target: U_WAIT,    op: OP_NONE,    nxt: NX_INC};
      U_SWEEP:   w = '{cond: C_SWEEP_DONE, target: U_WAIT,    op: OP_CLEAR,   nxt: NX_SELF};
      default:   w = '{cond: C_NEVER,      target: U_WAIT,    op: OP_NONE,    nxt: NX_WAIT};
    endcase
    return w;
  endfunction

endpackage

[src/page_lcd_framebuffer_refresh.sv]
// ----------------------------------------------------------------------------
// page_lcd_framebuffer_refresh: page-addressed monochrome panel frame store
// Keeps a 1-bit-per-pixel image and turns draw, clear, flush, init, shutdown
// and tick commands into the byte stream for a page-addressed panel.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one command per beat: in_tuser holds the command
//   code, in_tdata the pixel coordinates and value for a draw. Only a tick
//   with a byte pending produces an out_ beat: out_tdata holds the panel
//   byte and the backlight level, out_tuser marks data versus command and
//   out_tlast marks the final byte of a refresh or of the display-off.
//   A microcoded step counter runs each command through a single-port frame
//   memory: a draw reads the addressed byte, then writes it back (neither
//   when ignored), a tick reads at the scan position, then offers the
//   pending byte (neither if none is pending), others run the control step.
//   Clear and init zero all PAGE_TOTAL*PANEL_WIDTH bytes in a sweep with
//   in_tready low; the same sweep runs after reset before the first beat. A
//   waiting tick result does not block other commands; only a further tick
//   with a byte pending stalls until out_tready frees the register.
// ----------------------------------------------------------------------------
module page_lcd_framebuffer_refresh
  import plfr_pkg::*;
#(
  parameter int PANEL_WIDTH = 128,
  parameter int PAGE_TOTAL  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] x_pos, [14:8] y_pos, [15] pixel_on
  input  logic [2:0]  in_tuser,   // [2:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] backlight, [15:9] zero
  output logic [0:0]  out_tuser,  // [0] is_data
  output logic        out_tlast
);

  localparam int DEPTH = PANEL_WIDTH * PAGE_TOTAL;
  localparam int MA_W  = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int COL_W = $clog2(PANEL_WIDTH);
  localparam int PG_W  = (PAGE_TOTAL > 1) ? $clog2(PAGE_TOTAL) : 1;
  localparam int HEIGHT = 8 * PAGE_TOTAL;

  // Sequencer and control state.
  upc_t              pc_r, pc_nxt;
  logic              ready_r, ready_nxt;
  logic              bl_r, bl_nxt;
  phase_t            phase_r, phase_nxt;
  logic [2:0]        init_r, init_nxt;
  logic [PG_W-1:0]   page_r, page_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [1:0]        hdr_r, hdr_nxt;
  logic              clr_req_r, clr_req_nxt;
  logic [CNT_W-1:0]  sweep_cnt_r, sweep_cnt_nxt;
  logic              out_vld_r, out_vld_nxt;

  // Payload registers.
  logic [2:0]        cmd_r, cmd_nxt;
  logic [7:0]        x_r, x_nxt;
  logic [6:0]        y_r, y_nxt;
  logic              on_r, on_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_data_r, out_data_nxt;
  logic              out_bl_r, out_bl_nxt;
  logic              out_last_r, out_last_nxt;

  // Frame memory.
  logic [7:0]        mem [DEPTH];
  logic [7:0]        rdata_r;
  logic [MA_W-1:0]   mem_addr;
  logic [7:0]        mem_wdata;
  logic              mem_we;
  logic              mem_re;

  ucw_t              cw;
  logic              cond_hit;
  logic              do_op;
  logic [MA_W-1:0]   draw_addr;
  logic [MA_W-1:0]   scan_addr;
  logic [7:0]        pix_mask;

  assign cw = ucode(pc_r);

  assign draw_addr = MA_W'(32'(y_r[6:3]) * PANEL_WIDTH + 32'(x_r));
  assign scan_addr = MA_W'(32'(page_r) * PANEL_WIDTH + 32'(col_r));
  assign pix_mask  = 8'(1) << y_r[2:0];

  always_comb begin
    case (cw.cond)
      C_NEVER:      cond_hit = 1'b0;
      C_NO_BEAT:    cond_hit = !in_tvalid;
      C_NOT_DRAW:   cond_hit = (cmd_r != CMD_DRAW);
      C_DRAW_SKIP:  cond_hit = !ready_r || ({1'b0, x_r} >= 9'(PANEL_WIDTH)) ||
                               ({1'b0, y_r} >= 8'(HEIGHT));
      C_NOT_TICK:   cond_hit = (cmd_r != CMD_TICK);
      C_IDLE_PHASE: cond_hit = (phase_r == PH_IDLE);
      C_OUT_FULL:   cond_hit = out_vld_r && !out_tready;
      C_NO_CLEAR:   cond_hit = !clr_req_r;
      C_SWEEP_DONE: cond_hit = (sweep_cnt_r == CNT_W'(DEPTH));
      default:      cond_hit = 1'b1;
    endcase
  end

  assign do_op     = !cond_hit;
  assign in_tready = (cw.op == OP_LATCH);

  always_comb begin
    if (cond_hit) begin
      pc_nxt = cw.target;
    end else begin
      case (cw.nxt)
        NX_INC:  pc_nxt = pc_r + upc_t'(1);
        NX_WAIT: pc_nxt = U_WAIT;
        NX_SELF: pc_nxt = pc_r;
        default: pc_nxt = U_WAIT;
      endcase
    end
  end

  // Datapath driven by the current control word.
  always_comb begin
    ready_nxt     = ready_r;
    bl_nxt        = bl_r;
    phase_nxt     = phase_r;
    init_nxt      = init_r;
    page_nxt      = page_r;
    col_nxt       = col_r;
    hdr_nxt       = hdr_r;
    clr_req_nxt   = clr_req_r;
    sweep_cnt_nxt = sweep_cnt_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    cmd_nxt       = cmd_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    on_nxt        = on_r;
    out_byte_nxt  = out_byte_r;
    out_data_nxt  = out_data_r;
    out_bl_nxt    = out_bl_r;
    out_last_nxt  = out_last_r;
    mem_addr      = draw_addr;
    mem_wdata     = 8'h00;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    if (do_op) begin
      case (cw.op)
        OP_LATCH: begin
          cmd_nxt = in_tuser;
          x_nxt   = in_tdata[7:0];
          y_nxt   = in_tdata[14:8];
          on_nxt  = in_tdata[15];
        end
        OP_DRAW_RD: begin
          mem_re = 1'b1;
        end
        OP_DRAW_WR: begin
          mem_we    = 1'b1;
          mem_wdata = on_r ? (rdata_r | pix_mask) : (rdata_r & ~pix_mask);
        end
        OP_TICK_RD: begin
          mem_addr = scan_addr;
          mem_re   = 1'b1;
        end
        OP_EMIT: begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = 1'b0;
          out_last_nxt = 1'b0;
          out_byte_nxt = 8'h00;
          case (phase_r)
            PH_INIT: begin
              out_byte_nxt = SETUP_BYTES[init_r];
              if (init_r == 3'(SETUP_LEN - 1)) begin
                bl_nxt    = 1'b1;
                phase_nxt = PH_HEAD;
                page_nxt  = '0;
                hdr_nxt   = '0;
                col_nxt   = '0;
              end else begin
                init_nxt = init_r + 3'd1;
              end
            end
            PH_HEAD: begin
              case (hdr_r)
                2'd0:    out_byte_nxt = {PAGE_CMD_HI, 4'(page_r)};
                2'd1:    out_byte_nxt = COL_LO_CMD;
                default: out_byte_nxt = COL_HI_CMD;
              endcase
              if (hdr_r >= 2'd2) begin
                hdr_nxt   = '0;
                col_nxt   = '0;
                phase_nxt = PH_DATA;
              end else begin
                hdr_nxt = hdr_r + 2'd1;
              end
            end
            PH_DATA: begin
              out_data_nxt = 1'b1;
              out_byte_nxt = rdata_r;
              if (col_r == COL_W'(PANEL_WIDTH - 1)) begin
                col_nxt = '0;
                if (page_r == PG_W'(PAGE_TOTAL - 1)) begin
                  page_nxt     = '0;
                  out_last_nxt = 1'b1;
                  phase_nxt    = PH_IDLE;
                end else begin
                  page_nxt  = page_r + PG_W'(1);
                  hdr_nxt   = '0;
                  phase_nxt = PH_HEAD;
                end
              end else begin
                col_nxt = col_r + COL_W'(1);
              end
            end
            PH_OFF: begin
              out_byte_nxt = DISP_OFF_CMD;
              bl_nxt       = 1'b0;
              out_last_nxt = 1'b1;
              phase_nxt    = PH_IDLE;
            end
            default: begin
              out_vld_nxt = out_vld_r && !out_tready;
            end
          endcase
          out_bl_nxt = bl_nxt;
        end
        OP_CTRL: begin
          clr_req_nxt   = 1'b0;
          sweep_cnt_nxt = '0;
          case (cmd_r)
            CMD_CLEAR, CMD_FLUSH: begin
              if (ready_r) begin
                clr_req_nxt = (cmd_r == CMD_CLEAR);
                // A refresh asked for during set-up waits for set-up to end.
                if (phase_r != PH_INIT) begin
                  phase_nxt = PH_HEAD;
                  page_nxt  = '0;
                  hdr_nxt   = '0;
                  col_nxt   = '0;
                end
              end
            end
            CMD_INIT: begin
              if (!ready_r) begin
                ready_nxt   = 1'b1;
                bl_nxt      = 1'b0;
                clr_req_nxt = 1'b1;
                phase_nxt   = PH_INIT;
                init_nxt    = '0;
              end
            end
            CMD_SHUTDOWN: begin
              if (ready_r) begin
                ready_nxt = 1'b0;
                phase_nxt = PH_OFF;
              end
            end
            default: begin
              clr_req_nxt = 1'b0;
            end
          endcase
        end
        OP_CLEAR: begin
          mem_addr      = sweep_cnt_r[MA_W-1:0];
          mem_we        = 1'b1;
          mem_wdata     = 8'h00;
          sweep_cnt_nxt = sweep_cnt_r + CNT_W'(1);
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= U_SWEEP;
      ready_r     <= 1'b0;
      bl_r        <= 1'b0;
      phase_r     <= PH_IDLE;
      init_r      <= '0;
      page_r      <= '0;
      col_r       <= '0;
      hdr_r       <= '0;
      clr_req_r   <= 1'b0;
      sweep_cnt_r <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      ready_r     <= ready_nxt;
      bl_r        <= bl_nxt;
      phase_r     <= phase_nxt;
      init_r      <= init_nxt;
      page_r      <= page_nxt;
      col_r       <= col_nxt;
      hdr_r       <= hdr_nxt;
      clr_req_r   <= clr_req_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    on_r       <= on_nxt;
    out_byte_r <= out_byte_nxt;
    out_data_r <= out_data_nxt;
    out_bl_r   <= out_bl_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0, out_bl_r, out_byte_r};
  assign out_tuser  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[src/plfr_checker.sv]
// ----------------------------------------------------------------------------
// plfr_checker: port-level checks for page_lcd_framebuffer_refresh
// Watches the output channel for held beats, for the backlight behavior
// that goes with the set-up and display-off command bytes, and for reset.
// ----------------------------------------------------------------------------
module plfr_checker
  import plfr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // A command beat that ends a sequence is the display-off byte, backlight low.
  a_off_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && !out_tuser[0] |->
      (out_tdata[7:0] == DISP_OFF_CMD) && !out_tdata[8])
    else $error("final command beat is not display-off with backlight low");

  // The last set-up byte raises the backlight.
  a_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] && (out_tdata[7:0] == SETUP_BYTES[SETUP_LEN - 1])
      |-> out_tdata[8])
    else $error("display-on beat without backlight");

  // Reset empties the output register and holds off input while the store clears.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("output or input ready active right after reset");

endmodule

bind page_lcd_framebuffer_refresh plfr_checker u_plfr_checker (.*);
